// ===== rtl/core/nv12bd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nv12bd_pkg: shared types and constants of the NV12 to BGRA downscaler
// Holds the frame size limits, field widths, register indexes and the
// sample and color structures passed between the downscaler modules.
// ----------------------------------------------------------------------------
package nv12bd_pkg;

	localparam int MAX_SOURCE_SIDE = 4096;
	localparam int MAX_OUTPUT_SIDE = 960;

	localparam int SRC_SIDE_W = 13;
	localparam int OUT_SIDE_W = 10;
	localparam int CFG_DATA_W = 13;
	localparam int SCOL_W     = 12;
	localparam int SROW_W     = 13;
	localparam int ERR_W      = 14;

	typedef enum logic [1:0] {
		CFG_SRC_WIDTH  = 2'd0,
		CFG_SRC_HEIGHT = 2'd1,
		CFG_OUT_WIDTH  = 2'd2,
		CFG_OUT_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] chroma_blue;
		logic [7:0] chroma_red;
	} ycc_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} bgr_t;

endpackage
`default_nettype wire

// ===== rtl/core/nv12bd_pix_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nv12bd_pix_if: source pixel channel
// Carries one YCbCr source pixel per transfer with a start-of-frame flag.
// ----------------------------------------------------------------------------
interface nv12bd_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] luma;
	logic [7:0] chroma_blue;
	logic [7:0] chroma_red;
	logic       frame_start;

	modport source (output valid, output luma, output chroma_blue, output chroma_red,
		output frame_start, input ready);
	modport sink (input valid, input luma, input chroma_blue, input chroma_red,
		input frame_start, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/nv12bd_bgr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nv12bd_bgr_if: output pixel channel
// Carries one converted BGR pixel per transfer with its output coordinates.
// ----------------------------------------------------------------------------
interface nv12bd_bgr_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;
	logic [9:0] out_col;
	logic [9:0] out_row;
	logic       frame_last;

	modport source (output valid, output blue, output green, output red, output out_col,
		output out_row, output frame_last, input ready);
	modport sink (input valid, input blue, input green, input red, input out_col,
		input out_row, input frame_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/nv12_to_bgra_nearest_downscaler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nv12_to_bgra_nearest_downscaler: nearest-neighbor downscaler with BT.709
// color conversion
// Picks source pixels from a raster stream and emits them as BGR pixels with
// their output coordinates.
// ----------------------------------------------------------------------------
// The block takes one source pixel per clock in raster order, unless the
// output stalls, and keeps one pixel out of each scaled cell: output column x
// takes source column floor(x * src_width / out_width), and rows are picked
// the same way, using error accumulators in place of a divider. A pixel with
// frame_start set clears all position state before it is taken. Each picked
// pixel is converted with BT.709 video-range integer coefficients and leaves
// as one transfer on the result channel; alpha is implied to be 255. The
// position update is combinational and registered on each accepted pixel, so
// the block sustains one pixel per clock unless the output stalls. A picked
// pixel passes the pick register, then the color converter and the output
// register. The output register lets a new pixel enter while a finished
// result waits to be taken. Frames with a side below 2, a source side above
// 4096 or an output side above 960 produce no output. An output size larger
// than the source is saturated to the source size. Registers should only be
// written while no picked pixel is in flight.
// ----------------------------------------------------------------------------
module nv12_to_bgra_nearest_downscaler (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  nv12bd_pkg::cfg_reg_t                cfg_index,
	input  wire [nv12bd_pkg::CFG_DATA_W-1:0]    cfg_data,
	nv12bd_pix_if.sink                          pixels,
	nv12bd_bgr_if.source                        results
);
	import nv12bd_pkg::*;

	// Configuration registers.
	logic [SRC_SIDE_W-1:0] src_width_q, src_height_q;
	logic [OUT_SIDE_W-1:0] out_width_q, out_height_q;

	// Position state.
	logic [SCOL_W-1:0]     scol_q;
	logic [SROW_W-1:0]     srow_q;
	logic [OUT_SIDE_W-1:0] ocol_q, orow_q;
	logic [ERR_W-1:0]      cerr_q, rerr_q;
	logic                  picked_q;

	// Pick register and output register.
	logic                  valid_s1;
	ycc_t                  ycc_s1;
	logic [OUT_SIDE_W-1:0] col_s1, row_s1;
	logic                  last_s1;
	logic                  out_valid_q;
	bgr_t                  bgr_q;
	logic [OUT_SIDE_W-1:0] col_q, row_q;
	logic                  last_q;

	bgr_t                  bgr_conv;

	// Working signals of the position update.
	logic                  cfg_ok;
	logic [OUT_SIDE_W-1:0] owe, ohe;
	logic [SCOL_W-1:0]     cur_scol;
	logic [SROW_W-1:0]     cur_srow;
	logic [OUT_SIDE_W-1:0] cur_ocol, cur_orow;
	logic [ERR_W-1:0]      cur_cerr, cur_rerr;
	logic                  cur_picked;
	logic                  active, col_hit, emit, row_end;
	logic [ERR_W-1:0]      cerr_a, rerr_a;
	logic [OUT_SIDE_W-1:0] orow_a;
	logic [SRC_SIDE_W-1:0] scol_inc;
	logic [SCOL_W-1:0]     scol_n;
	logic [SROW_W-1:0]     srow_n;
	logic [OUT_SIDE_W-1:0] ocol_n, orow_n;
	logic [ERR_W-1:0]      cerr_n, rerr_n;
	logic                  picked_n;

	// Handshake.
	logic out_free, s1_move, accept;

	assign out_free = !out_valid_q || results.ready;
	assign s1_move  = valid_s1 && out_free;
	assign pixels.ready = !valid_s1 || out_free;
	assign accept   = pixels.valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRC_SIDE_W'(1920);
			src_height_q <= SRC_SIDE_W'(1080);
			out_width_q  <= OUT_SIDE_W'(960);
			out_height_q <= OUT_SIDE_W'(540);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SRC_WIDTH:  src_width_q  <= cfg_data;
				CFG_SRC_HEIGHT: src_height_q <= cfg_data;
				CFG_OUT_WIDTH:  out_width_q  <= cfg_data[OUT_SIDE_W-1:0];
				CFG_OUT_HEIGHT: out_height_q <= cfg_data[OUT_SIDE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		// A frame start clears the position before the pixel is handled.
		if (pixels.frame_start) begin
			cur_scol   = '0;
			cur_srow   = '0;
			cur_ocol   = '0;
			cur_orow   = '0;
			cur_cerr   = '0;
			cur_rerr   = '0;
			cur_picked = 1'b1;
		end else begin
			cur_scol   = scol_q;
			cur_srow   = srow_q;
			cur_ocol   = ocol_q;
			cur_orow   = orow_q;
			cur_cerr   = cerr_q;
			cur_rerr   = rerr_q;
			cur_picked = picked_q;
		end

		cfg_ok = src_width_q >= SRC_SIDE_W'(2) && src_height_q >= SRC_SIDE_W'(2)
			&& src_width_q <= SRC_SIDE_W'(MAX_SOURCE_SIDE)
			&& src_height_q <= SRC_SIDE_W'(MAX_SOURCE_SIDE)
			&& out_width_q >= OUT_SIDE_W'(2) && out_height_q >= OUT_SIDE_W'(2)
			&& out_width_q <= OUT_SIDE_W'(MAX_OUTPUT_SIDE)
			&& out_height_q <= OUT_SIDE_W'(MAX_OUTPUT_SIDE);

		// The output size never exceeds the source size.
		owe = ({3'd0, out_width_q} > src_width_q) ? src_width_q[OUT_SIDE_W-1:0]
			: out_width_q;
		ohe = ({3'd0, out_height_q} > src_height_q) ? src_height_q[OUT_SIDE_W-1:0]
			: out_height_q;

		// Pixels past the last source row are taken and ignored until the next frame start.
		active  = cfg_ok && (cur_srow < src_height_q);
		col_hit = (cur_cerr < {4'd0, owe}) && (cur_ocol < owe);
		emit    = active && cur_picked && col_hit;

		cerr_a = col_hit ? cur_cerr + {1'b0, src_width_q} : cur_cerr;
		ocol_n = col_hit ? cur_ocol + OUT_SIDE_W'(1) : cur_ocol;
		cerr_n = (cerr_a >= {4'd0, owe}) ? cerr_a - {4'd0, owe} : '0;
		scol_inc = {1'b0, cur_scol} + SRC_SIDE_W'(1);
		row_end  = scol_inc >= src_width_q;
		scol_n   = scol_inc[SCOL_W-1:0];
		srow_n   = cur_srow;
		orow_n   = cur_orow;
		rerr_n   = cur_rerr;
		picked_n = cur_picked;
		rerr_a   = cur_picked ? cur_rerr + {1'b0, src_height_q} : cur_rerr;
		orow_a   = cur_picked ? cur_orow + OUT_SIDE_W'(1) : cur_orow;

		if (row_end) begin
			scol_n   = '0;
			ocol_n   = '0;
			cerr_n   = '0;
			orow_n   = orow_a;
			rerr_n   = (rerr_a >= {4'd0, ohe}) ? rerr_a - {4'd0, ohe} : '0;
			srow_n   = cur_srow + SROW_W'(1);
			picked_n = (rerr_n < {4'd0, ohe}) && (orow_a < ohe);
		end

		// An ignored pixel leaves only the clearing done by a frame start.
		if (!active) begin
			scol_n   = cur_scol;
			srow_n   = cur_srow;
			ocol_n   = cur_ocol;
			orow_n   = cur_orow;
			cerr_n   = cur_cerr;
			rerr_n   = cur_rerr;
			picked_n = cur_picked;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scol_q   <= '0;
			srow_q   <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
			cerr_q   <= '0;
			rerr_q   <= '0;
			picked_q <= 1'b1;
		end else if (accept) begin
			scol_q   <= scol_n;
			srow_q   <= srow_n;
			ocol_q   <= ocol_n;
			orow_q   <= orow_n;
			cerr_q   <= cerr_n;
			rerr_q   <= rerr_n;
			picked_q <= picked_n;
		end
	end

	// Valid flags of the pick register and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && emit) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload of a picked pixel, held until the output register takes it.
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			ycc_s1.luma        <= pixels.luma;
			ycc_s1.chroma_blue <= pixels.chroma_blue;
			ycc_s1.chroma_red  <= pixels.chroma_red;
			col_s1  <= cur_ocol;
			row_s1  <= cur_orow;
			last_s1 <= (cur_ocol == owe - OUT_SIDE_W'(1))
				&& (cur_orow == ohe - OUT_SIDE_W'(1));
		end
		if (s1_move) begin
			bgr_q  <= bgr_conv;
			col_q  <= col_s1;
			row_q  <= row_s1;
			last_q <= last_s1;
		end
	end

	nv12bd_color u_color (
		.ycc (ycc_s1),
		.bgr (bgr_conv)
	);

	assign results.valid      = out_valid_q;
	assign results.blue       = bgr_q.blue;
	assign results.green      = bgr_q.green;
	assign results.red        = bgr_q.red;
	assign results.out_col    = col_q;
	assign results.out_row    = row_q;
	assign results.frame_last = last_q;

endmodule
`default_nettype wire

// ===== rtl/core/nv12bd_color.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nv12bd_color: BT.709 video-range YCbCr to BGR conversion
// Integer coefficients with rounding, a shift by eight and a clamp to 0..255.
// ----------------------------------------------------------------------------
module nv12bd_color (
	input  nv12bd_pkg::ycc_t ycc,
	output nv12bd_pkg::bgr_t bgr
);
	import nv12bd_pkg::*;

	logic signed [19:0] ys, ds, es, c;
	logic signed [19:0] vb, vg, vr;

	function automatic logic [7:0] clamp8(input logic signed [19:0] v);
		logic [11:0] s;
		begin
			s = v[19:8];
			if (v < 0) begin
				clamp8 = 8'd0;
			end else if (s > 12'd255) begin
				clamp8 = 8'd255;
			end else begin
				clamp8 = s[7:0];
			end
		end
	endfunction

	always_comb begin
		ys = $signed({12'd0, ycc.luma}) - 20'sd16;
		ds = $signed({12'd0, ycc.chroma_blue}) - 20'sd128;
		es = $signed({12'd0, ycc.chroma_red}) - 20'sd128;
		c  = ys * 20'sd298;
		vb = c + ds * 20'sd541 + 20'sd128;
		vg = c - ds * 20'sd55 - es * 20'sd136 + 20'sd128;
		vr = c + es * 20'sd459 + 20'sd128;
		bgr.blue  = clamp8(vb);
		bgr.green = clamp8(vg);
		bgr.red   = clamp8(vr);
	end

endmodule
`default_nettype wire
